// ===== design/nmte_pkg.sv =====
// Package for the neighbor max traversal end filter.
// Holds register indexes, reset values and the control structs shared between the modules.
// Depends on nothing.
`default_nettype none

package nmte_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // Field widths of the configuration registers.
   localparam int INC_BITS   = 16;
   localparam int CELLS_BITS = 11;
   localparam int LINES_BITS = 16;

   // Reset values of the configuration registers.
   localparam logic [INC_BITS-1:0]   BORDER_INC_RESET = 16'd180;
   localparam logic [CELLS_BITS-1:0] CELLS_RESET      = 11'd1024;
   localparam logic [LINES_BITS-1:0] LINES_RESET      = 16'd1024;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BORDER_INCREMENT = 2'd0,
      CSR_CELLS_PER_LINE   = 2'd1,
      CSR_LINE_COUNT       = 2'd2
   } csr_index_type;

   // One configuration write as seen by the blocks that hold registers.
   typedef struct packed {
      logic                     valid;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
   } csr_write_type;

   // Position of the cell whose result is produced, relative to the frame edges.
   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
      logic last;
   } pos_flags_type;

endpackage

`default_nettype wire

// ===== design/nmte_frame_ctrl.sv =====
// Frame position tracking for the traversal end filter: geometry registers,
// input column, fill count and output position. Uses nmte_pkg.
`default_nettype none

module nmte_frame_ctrl #(
   parameter int MAX_LINE = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire nmte_pkg::csr_write_type        csr_write,
   input  wire logic                          accept,
   input  wire logic                          drain,
   output logic                               drop,
   output logic                               emit,
   output logic [$clog2(MAX_LINE)-1:0]        column,
   output nmte_pkg::pos_flags_type             flags
);
   import nmte_pkg::*;

   localparam int CB = $clog2(MAX_LINE);
   localparam int WB = $clog2(MAX_LINE + 1);
   localparam int HB = $clog2(MAX_LINE + 3);
   localparam int PB = WB + LINES_BITS;
   localparam int XB = (WB > CELLS_BITS) ? WB : CELLS_BITS;
   localparam int RESET_W = (int'(CELLS_RESET) > MAX_LINE) ? MAX_LINE : int'(CELLS_RESET);
   localparam int RESET_PRODUCT = RESET_W * int'(LINES_RESET);

   // Width of a line as the datapath sees it: zero counts as one, wide is clipped.
   function automatic logic [WB-1:0] eff_width(input logic [CELLS_BITS-1:0] cells);
      logic [XB-1:0] wide;
      wide = XB'(cells);
      if (cells == '0) begin
         return WB'(1);
      end else if (wide > XB'(MAX_LINE)) begin
         return WB'(MAX_LINE);
      end
      return wide[WB-1:0];
   endfunction

   function automatic logic [LINES_BITS-1:0] eff_lines(input logic [LINES_BITS-1:0] lines);
      return (lines == '0) ? LINES_BITS'(1) : lines;
   endfunction

   logic [CELLS_BITS-1:0] cells_ff, cells_in;
   logic [LINES_BITS-1:0] lines_ff, lines_in;
   logic [PB-1:0]         product_ff, product_in;
   logic [CB-1:0]         in_col_ff, in_col_in;
   logic [HB-1:0]         held_ff, held_in;
   logic [CB-1:0]         out_col_ff, out_col_in;
   logic [LINES_BITS-1:0] out_line_ff, out_line_in;
   logic [PB-1:0]         out_count_ff, out_count_in;

   logic [WB-1:0]         width;
   logic [LINES_BITS-1:0] lines;
   logic [WB:0]           in_col_inc;
   logic [WB:0]           out_col_inc;
   logic [LINES_BITS:0]   out_line_inc;
   logic [PB:0]           out_count_inc;
   logic [HB-1:0]         held_inc;
   logic                  in_wrap;

   // Geometry registers; the frame size product follows the next values.
   always_comb begin
      cells_in = cells_ff;
      lines_in = lines_ff;
      if (csr_write.valid && csr_write.index == CSR_CELLS_PER_LINE) begin
         cells_in = csr_write.data[CELLS_BITS-1:0];
      end
      if (csr_write.valid && csr_write.index == CSR_LINE_COUNT) begin
         lines_in = csr_write.data[LINES_BITS-1:0];
      end
      product_in = PB'(eff_width(cells_in)) * PB'(eff_lines(lines_in));
   end

   assign width = eff_width(cells_ff);
   assign lines = eff_lines(lines_ff);

   // Position tests for the incoming beat and for the result it may release.
   assign in_col_inc    = (WB+1)'(in_col_ff) + (WB+1)'(1);
   assign in_wrap       = in_col_inc >= (WB+1)'(width);
   assign held_inc      = held_ff + HB'(1);
   assign out_col_inc   = (WB+1)'(out_col_ff) + (WB+1)'(1);
   assign out_line_inc  = (LINES_BITS+1)'(out_line_ff) + (LINES_BITS+1)'(1);
   assign out_count_inc = (PB+1)'(out_count_ff) + (PB+1)'(1);

   assign drop   = drain && (held_ff == '0);
   assign emit   = held_inc >= (HB'(width) + HB'(2));
   assign column = in_col_ff;

   assign flags.top    = (out_line_ff == '0);
   assign flags.bottom = out_line_inc >= (LINES_BITS+1)'(lines);
   assign flags.left   = (out_col_ff == '0);
   assign flags.right  = out_col_inc >= (WB+1)'(width);
   assign flags.last   = out_count_inc >= (PB+1)'(product_ff);

   // Counter updates for one accepted beat that enters the line stores.
   always_comb begin
      in_col_in    = in_col_ff;
      held_in      = held_ff;
      out_col_in   = out_col_ff;
      out_line_in  = out_line_ff;
      out_count_in = out_count_ff;
      if (accept && !drop) begin
         in_col_in = in_wrap ? '0 : in_col_inc[CB-1:0];
         held_in   = held_inc;
         if (emit) begin
            held_in = HB'(width) + HB'(1);
            if (flags.last) begin
               out_count_in = '0;
               out_col_in   = '0;
               out_line_in  = '0;
               if (drain) begin
                  in_col_in = '0;
                  held_in   = '0;
               end
            end else begin
               out_count_in = out_count_inc[PB-1:0];
               if (flags.right) begin
                  out_col_in  = '0;
                  out_line_in = flags.bottom ? '0 : out_line_inc[LINES_BITS-1:0];
               end else begin
                  out_col_in = out_col_inc[CB-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff     <= CELLS_RESET;
         lines_ff     <= LINES_RESET;
         product_ff   <= PB'(RESET_PRODUCT);
         in_col_ff    <= '0;
         held_ff      <= '0;
         out_col_ff   <= '0;
         out_line_ff  <= '0;
         out_count_ff <= '0;
      end else begin
         cells_ff     <= cells_in;
         lines_ff     <= lines_in;
         product_ff   <= product_in;
         in_col_ff    <= in_col_in;
         held_ff      <= held_in;
         out_col_ff   <= out_col_in;
         out_line_ff  <= out_line_in;
         out_count_ff <= out_count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/nmte_line_buf.sv =====
// Line stores of the traversal end filter: one memory holding the two previous
// lines per column, with write-back forwarding. Uses nmte_pkg.
`default_nettype none

module nmte_line_buf #(
   parameter int MAX_LINE  = 1024,
   parameter int TIME_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic                          load,
   input  wire logic [$clog2(MAX_LINE)-1:0]   column,
   input  wire logic [TIME_BITS:0]            new_cell,
   input  wire logic                          emit,
   input  wire nmte_pkg::pos_flags_type        flags,
   output logic                               s1_valid,
   output logic                               s1_emit,
   output nmte_pkg::pos_flags_type             s1_flags,
   output logic [TIME_BITS:0]                 s1_above,
   output logic [TIME_BITS:0]                 s1_mid,
   output logic [TIME_BITS:0]                 s1_cell
);
   import nmte_pkg::*;

   localparam int CB = $clog2(MAX_LINE);
   localparam int C  = TIME_BITS + 1;

   // Entry layout: upper half is the line just above, lower half the one before.
   logic [2*C-1:0]  store_mem [MAX_LINE];
   logic [2*C-1:0]  rd_ff;
   logic [2*C-1:0]  fwd_ff;
   logic            fwd_sel_ff;
   logic [2*C-1:0]  pair;
   logic [2*C-1:0]  write_data;
   logic            s1_valid_ff;
   logic            s1_emit_ff;
   pos_flags_type   s1_flags_ff;
   logic [CB-1:0]   s1_col_ff;
   logic [C-1:0]    s1_cell_ff;

   // A beat that reads the column still being written takes the new entry.
   assign pair       = fwd_sel_ff ? fwd_ff : rd_ff;
   assign write_data = {s1_cell_ff, pair[2*C-1:C]};

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_ff      <= store_mem[column];
         fwd_sel_ff <= s1_valid_ff && (s1_col_ff == column);
         fwd_ff     <= write_data;
         if (s1_valid_ff) begin
            store_mem[s1_col_ff] <= write_data;
         end
      end
   end

   // Stage one payload.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_emit_ff  <= emit;
         s1_flags_ff <= flags;
         s1_col_ff   <= column;
         s1_cell_ff  <= new_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= load;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_emit  = s1_emit_ff;
   assign s1_flags = s1_flags_ff;
   assign s1_above = pair[C-1:0];
   assign s1_mid   = pair[2*C-1:C];
   assign s1_cell  = s1_cell_ff;

endmodule

`default_nettype wire

// ===== design/nmte_window.sv =====
// 3x3 window of the traversal end filter and the neighbor maximum stage.
// Uses nmte_pkg for the position flags.
`default_nettype none

module nmte_window #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire logic                    s1_valid,
   input  wire logic                    s1_emit,
   input  wire nmte_pkg::pos_flags_type  s1_flags,
   input  wire logic [TIME_BITS:0]      s1_above,
   input  wire logic [TIME_BITS:0]      s1_mid,
   input  wire logic [TIME_BITS:0]      s1_cell,
   output logic                         s3_valid,
   output logic                         s3_last,
   output logic                         s3_never,
   output logic [TIME_BITS-1:0]         s3_own,
   output logic [TIME_BITS-1:0]         s3_best
);
   import nmte_pkg::*;

   localparam int C = TIME_BITS + 1;

   logic [C-1:0]         win_ff [9];
   logic                 s2_valid_ff;
   pos_flags_type        s2_flags_ff;
   logic [TIME_BITS-1:0] masked [9];
   logic [TIME_BITS-1:0] lvl1 [4];
   logic [TIME_BITS-1:0] lvl2 [2];
   logic [TIME_BITS-1:0] best;
   logic                 s3_valid_ff;
   logic                 s3_last_ff;
   logic                 s3_never_ff;
   logic [TIME_BITS-1:0] s3_own_ff;
   logic [TIME_BITS-1:0] s3_best_ff;

   // Window shifts left by one column for every beat out of the line stores.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (advance && s1_valid) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]   <= win_ff[r*3+1];
            win_ff[r*3+1] <= win_ff[r*3+2];
         end
         win_ff[2] <= s1_above;
         win_ff[5] <= s1_mid;
         win_ff[8] <= s1_cell;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_flags_ff <= s1_flags;
      end
   end

   // Neighbors off the grid or never ignited count as zero; the center is left out.
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         masked[i] = win_ff[i][TIME_BITS-1:0];
         if (win_ff[i][TIME_BITS] || i == 4 ||
             (i < 3 && s2_flags_ff.top) || (i > 5 && s2_flags_ff.bottom) ||
             (i % 3 == 0 && s2_flags_ff.left) || (i % 3 == 2 && s2_flags_ff.right)) begin
            masked[i] = '0;
         end
      end
   end

   // Maximum over the eight neighbors as a three-level compare tree.
   always_comb begin
      lvl1[0] = (masked[0] > masked[1]) ? masked[0] : masked[1];
      lvl1[1] = (masked[2] > masked[3]) ? masked[2] : masked[3];
      lvl1[2] = (masked[5] > masked[6]) ? masked[5] : masked[6];
      lvl1[3] = (masked[7] > masked[8]) ? masked[7] : masked[8];
      lvl2[0] = (lvl1[0] > lvl1[1]) ? lvl1[0] : lvl1[1];
      lvl2[1] = (lvl1[2] > lvl1[3]) ? lvl1[2] : lvl1[3];
      best    = (lvl2[0] > lvl2[1]) ? lvl2[0] : lvl2[1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_last_ff  <= s2_flags_ff.last;
         s3_never_ff <= win_ff[4][TIME_BITS];
         s3_own_ff   <= win_ff[4][TIME_BITS-1:0];
         s3_best_ff  <= best;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid && s1_emit;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   assign s3_valid = s3_valid_ff;
   assign s3_last  = s3_last_ff;
   assign s3_never = s3_never_ff;
   assign s3_own   = s3_own_ff;
   assign s3_best  = s3_best_ff;

endmodule

`default_nettype wire

// ===== design/nmte_result.sv =====
// Border rule and result register of the traversal end filter.
// Uses nmte_pkg for the increment width.
`default_nettype none

module nmte_result #(
   parameter int TIME_BITS = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire logic [nmte_pkg::INC_BITS-1:0] border_inc,
   input  wire logic                          s3_valid,
   input  wire logic                          s3_last,
   input  wire logic                          s3_never,
   input  wire logic [TIME_BITS-1:0]          s3_own,
   input  wire logic [TIME_BITS-1:0]          s3_best,
   output logic                               out_valid,
   output logic                               out_last,
   output logic                               out_never,
   output logic [TIME_BITS-1:0]               out_time
);
   import nmte_pkg::*;

   logic [TIME_BITS:0]   sum;
   logic [TIME_BITS-1:0] bordered;
   logic [TIME_BITS-1:0] end_time;
   logic                 valid_ff;
   logic                 last_ff;
   logic                 never_ff;
   logic [TIME_BITS-1:0] time_ff;

   // Own time plus the increment, held at the top of the range on overflow.
   assign sum      = (TIME_BITS+1)'(s3_own) + (TIME_BITS+1)'(border_inc);
   assign bordered = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

   always_comb begin
      if (s3_never) begin
         end_time = s3_own;
      end else if (s3_best <= s3_own) begin
         end_time = bordered;
      end else begin
         end_time = s3_best;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s3_valid) begin
         last_ff  <= s3_last;
         never_ff <= s3_never;
         time_ff  <= end_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= s3_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_last  = last_ff;
   assign out_never = never_ff;
   assign out_time  = time_ff;

endmodule

`default_nettype wire

// ===== design/neighbor_max_traversal_end.sv =====
// Top level of the neighbor max traversal end filter (3x3 dilation with a border rule).
// Uses nmte_pkg, nmte_frame_ctrl, nmte_line_buf, nmte_window and nmte_result.
//
// The block takes one raster cell per clock cycle and gives at most one result per
// cycle while no result waits on rsp_tready; a result for a cell leaves once the
// following line plus one more cell have entered, so drain beats are sent after a
// frame to push its last results out. Inside the block a result passes four
// registers: line store read, window shift, neighbor maximum, border rule; it is
// offered once the beat releasing it has passed all four. The pipeline moves as a
// whole; it holds only while a result waits on rsp_tready. The line stores are one
// memory of MAX_LINE entries that is not cleared after reset; rows off the grid are
// masked, so its contents before the first full line do not matter. Configuration
// writes are always taken and must only be made while no cells are held.
`default_nettype none

module neighbor_max_traversal_end #(
   parameter int MAX_LINE  = 1024,
   parameter int TIME_BITS = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Cell beats in.
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // Fields from bit 0: ignition_time, never_burns, zero fill.
   input  wire logic [((TIME_BITS+8)/8)*8-1:0]         req_tdata,
   // Field: drain.
   input  wire logic                                   req_tuser,
   // Result beats out.
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // Fields from bit 0: end_time, end_never, zero fill.
   output logic [((TIME_BITS+8)/8)*8-1:0]              rsp_tdata,
   // Field: frame_last.
   output logic                                        rsp_tlast,
   // Register writes.
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [nmte_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [nmte_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);
   import nmte_pkg::*;

   localparam int CB = $clog2(MAX_LINE);
   localparam int DW = ((TIME_BITS + 8) / 8) * 8;

   csr_write_type        csr_write;
   logic [INC_BITS-1:0]  border_inc_ff;
   logic                 advance;
   logic                 accept;
   logic                 drop;
   logic                 emit;
   logic [CB-1:0]        column;
   pos_flags_type        flags;
   logic [TIME_BITS:0]   new_cell;
   logic                 s1_valid;
   logic                 s1_emit;
   pos_flags_type        s1_flags;
   logic [TIME_BITS:0]   s1_above;
   logic [TIME_BITS:0]   s1_mid;
   logic [TIME_BITS:0]   s1_cell;
   logic                 s3_valid;
   logic                 s3_last;
   logic                 s3_never;
   logic [TIME_BITS-1:0] s3_own;
   logic [TIME_BITS-1:0] s3_best;
   logic                 out_never;
   logic [TIME_BITS-1:0] out_time;

   // Configuration writes are taken in every cycle.
   assign csr_ready       = 1'b1;
   assign csr_write.valid = csr_valid;
   assign csr_write.index = csr_index;
   assign csr_write.data  = csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         border_inc_ff <= BORDER_INC_RESET;
      end else if (csr_valid && csr_index == CSR_BORDER_INCREMENT) begin
         border_inc_ff <= csr_wdata[INC_BITS-1:0];
      end
   end

   // The whole pipeline steps whenever the result register is free or being taken.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;

   // A drain beat enters as a never-ignited cell of time zero.
   assign new_cell = req_tuser ? {1'b1, {TIME_BITS{1'b0}}} : req_tdata[TIME_BITS:0];

   nmte_frame_ctrl #(
      .MAX_LINE (MAX_LINE)
   ) u_frame_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .accept    (accept),
      .drain     (req_tuser),
      .drop      (drop),
      .emit      (emit),
      .column    (column),
      .flags     (flags)
   );

   nmte_line_buf #(
      .MAX_LINE  (MAX_LINE),
      .TIME_BITS (TIME_BITS)
   ) u_line_buf (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .load     (accept && !drop),
      .column   (column),
      .new_cell (new_cell),
      .emit     (emit),
      .flags    (flags),
      .s1_valid (s1_valid),
      .s1_emit  (s1_emit),
      .s1_flags (s1_flags),
      .s1_above (s1_above),
      .s1_mid   (s1_mid),
      .s1_cell  (s1_cell)
   );

   nmte_window #(
      .TIME_BITS (TIME_BITS)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .s1_valid (s1_valid),
      .s1_emit  (s1_emit),
      .s1_flags (s1_flags),
      .s1_above (s1_above),
      .s1_mid   (s1_mid),
      .s1_cell  (s1_cell),
      .s3_valid (s3_valid),
      .s3_last  (s3_last),
      .s3_never (s3_never),
      .s3_own   (s3_own),
      .s3_best  (s3_best)
   );

   nmte_result #(
      .TIME_BITS (TIME_BITS)
   ) u_result (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .border_inc (border_inc_ff),
      .s3_valid   (s3_valid),
      .s3_last    (s3_last),
      .s3_never   (s3_never),
      .s3_own     (s3_own),
      .s3_best    (s3_best),
      .out_valid  (rsp_tvalid),
      .out_last   (rsp_tlast),
      .out_never  (out_never),
      .out_time   (out_time)
   );

   assign rsp_tdata = {{(DW-TIME_BITS-1){1'b0}}, out_never, out_time};

`ifndef SYNTHESIS
   // A drain beat with nothing held must leave the line stores untouched.
   assert property (@(posedge clock) disable iff (reset)
      accept && drop |=> !s1_valid)
      else $error("idle drain beat entered the line stores");

   // A stalled pipeline keeps its stage one beat.
   assert property (@(posedge clock) disable iff (reset)
      s1_valid && !advance |=> s1_valid)
      else $error("stage one beat lost during a stall");

   // A beat that releases a result reaches the window stage with its emit mark.
   assert property (@(posedge clock) disable iff (reset)
      accept && !drop && emit |=> s1_valid && s1_emit)
      else $error("releasing beat lost its emit mark");
`endif

endmodule

`default_nettype wire
